// ===== sv/ssca_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the slab allocator
`timescale 1ns / 1ps

package ssca_pkg;

  // default geometry
  localparam int POOL_BYTES_DEF  = 65536;
  localparam int MIN_CHUNK_DEF   = 8;
  localparam int NUM_CLASSES_DEF = 9;

  // fixed field widths
  localparam int SLAB_W   = 13;
  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 16;
  localparam int STATUS_W = 3;

  localparam logic [SLAB_W-1:0] SLAB_RESET = 13'd4096;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_LARGE   = 3'd2,
    ST_OOM     = 3'd3,
    ST_BADFREE = 3'd4
  } status_t;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic    latch;
    logic    clear_step;
    logic    carve_init;
    logic    carve_step;
    logic    pop_write;
    logic    free_write;
    logic    respond;
    logic    resp_grant;
    status_t resp_status;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic op_free;
    logic zero;
    logic too_big;
    logic head_empty;
    logic oom;
    logic bad_addr;
    logic carve_last;
    logic clear_last;
    logic rec_bad;
  } sts_t;

endpackage

// ===== sv/ssca_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module ssca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ssca_ctrl.sv =====
// sequencing state machine for the slab allocator
`timescale 1ns / 1ps

module ssca_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ssca_pkg::sts_t sts,
  output ssca_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_CHECK    = 8'b0000_0100,
    S_CARVE    = 8'b0000_1000,
    S_POP_RD   = 8'b0001_0000,
    S_POP_WR   = 8'b0010_0000,
    S_FREE_RD  = 8'b0100_0000,
    S_FREE_CHK = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // state register, clearing pass runs first after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.resp_status = ssca_pkg::ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.op_free) begin
          if (sts.bad_addr) begin
            cmd.respond     = 1'b1;
            cmd.resp_status = ssca_pkg::ST_BADFREE;
            state_next      = S_IDLE;
          end else begin
            state_next = S_FREE_RD;
          end
        end else if (sts.zero) begin
          cmd.respond     = 1'b1;
          cmd.resp_status = ssca_pkg::ST_ZERO;
          state_next      = S_IDLE;
        end else if (sts.too_big) begin
          cmd.respond     = 1'b1;
          cmd.resp_status = ssca_pkg::ST_LARGE;
          state_next      = S_IDLE;
        end else if (sts.head_empty) begin
          if (sts.oom) begin
            cmd.respond     = 1'b1;
            cmd.resp_status = ssca_pkg::ST_OOM;
            state_next      = S_IDLE;
          end else begin
            cmd.carve_init = 1'b1;
            state_next     = S_CARVE;
          end
        end else begin
          state_next = S_POP_RD;
        end
      end
      S_CARVE: begin
        cmd.carve_step = 1'b1;
        if (sts.carve_last) begin
          state_next = S_POP_RD;
        end
      end
      S_POP_RD: begin
        state_next = S_POP_WR;
      end
      S_POP_WR: begin
        cmd.pop_write  = 1'b1;
        cmd.respond    = 1'b1;
        cmd.resp_grant = 1'b1;
        state_next     = S_IDLE;
      end
      S_FREE_RD: begin
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd.respond = 1'b1;
        if (sts.rec_bad) begin
          cmd.resp_status = ssca_pkg::ST_BADFREE;
        end else begin
          cmd.free_write = 1'b1;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // an accepted item always makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // every response ends the item
  a_respond_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |=> (state == S_IDLE))
    else $error("response issued without returning to idle");

endmodule

// ===== sv/ssca_dp.sv =====
// datapath of the slab allocator: free lists, granule records, bump pointer, result register
`timescale 1ns / 1ps

module ssca_dp #(
  parameter int POOL_BYTES  = ssca_pkg::POOL_BYTES_DEF,
  parameter int MIN_CHUNK   = ssca_pkg::MIN_CHUNK_DEF,
  parameter int NUM_CLASSES = ssca_pkg::NUM_CLASSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ssca_pkg::SLAB_W-1:0]   cfg_wdata,
  input  logic                          op,
  input  logic [ssca_pkg::SIZE_W-1:0]   size,
  input  logic [ssca_pkg::ADDR_W-1:0]   addr,
  input  ssca_pkg::cmd_t                cmd,
  output ssca_pkg::sts_t                sts,
  output logic                          done,
  output logic [ssca_pkg::ADDR_W-1:0]   alloc_addr,
  output logic [ssca_pkg::STATUS_W-1:0] status
);

  localparam int GRANULES  = POOL_BYTES / MIN_CHUNK;
  localparam int GRAN_W    = $clog2(GRANULES);
  localparam int LINK_W    = GRAN_W + 1;
  localparam int MIN_SHIFT = $clog2(MIN_CHUNK);
  localparam int CLS_W     = $clog2(NUM_CLASSES);
  localparam int REC_W     = $clog2(NUM_CLASSES + 1);
  localparam int BUMP_W    = $clog2(POOL_BYTES) + 1;
  localparam int SH_W      = $clog2(MIN_SHIFT + NUM_CLASSES);
  localparam int SLAB_W    = ssca_pkg::SLAB_W;

  // registers
  logic [SLAB_W-1:0]             slab_q;
  logic                          op_q;
  logic [ssca_pkg::SIZE_W-1:0]   size_q;
  logic [ssca_pkg::ADDR_W-1:0]   addr_q;
  logic [LINK_W-1:0]             heads [NUM_CLASSES];
  logic [BUMP_W-1:0]             bump;
  logic [BUMP_W-1:0]             carve_addr;
  logic [SLAB_W-1:0]             carve_left;
  logic [GRAN_W-1:0]             clr_idx;
  logic                          done_q;
  ssca_pkg::status_t             status_q;
  logic [ssca_pkg::ADDR_W-1:0]   alloc_addr_q;

  // combinational values
  logic [31:0]       need;
  logic [CLS_W-1:0]  cls;
  logic              found;
  logic [CLS_W-1:0]  free_cls;
  logic [CLS_W-1:0]  head_idx;
  logic [LINK_W-1:0] head;
  logic [GRAN_W-1:0] head_gran;
  logic [SH_W-1:0]   chunk_sh;
  logic [31:0]       chunk32;
  logic [SLAB_W-1:0] count;
  logic [SLAB_W-1:0] count_eff;
  logic [31:0]       total32;
  logic [31:0]       addr_wide;
  logic [GRAN_W-1:0] free_gran;
  logic [GRAN_W-1:0] carve_gran;
  logic [31:0]       grant32;
  logic [REC_W-1:0]  rec;
  logic [LINK_W-1:0] link_rdata;

  // ram ports
  logic              link_we;
  logic [GRAN_W-1:0] link_waddr;
  logic              rec_we;
  logic [GRAN_W-1:0] rec_waddr;
  logic [REC_W-1:0]  rec_wdata;

  // size class: smallest chunk that covers the request
  assign need = (size_q < ssca_pkg::SIZE_W'(MIN_CHUNK)) ? 32'(MIN_CHUNK) : 32'(size_q);

  always_comb begin
    cls   = '0;
    found = 1'b0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if ((32'(MIN_CHUNK) << k) >= need) begin
        cls   = CLS_W'(k);
        found = 1'b1;
      end
    end
  end

  // list head of the class in use
  assign free_cls  = CLS_W'(rec - REC_W'(1));
  assign head_idx  = op_q ? free_cls : cls;
  assign head      = (32'(head_idx) < 32'(NUM_CLASSES)) ? heads[head_idx] : '0;
  assign head_gran = GRAN_W'(head - LINK_W'(1));

  // slab geometry
  assign chunk_sh  = SH_W'(MIN_SHIFT) + SH_W'(cls);
  assign chunk32   = 32'(1) << chunk_sh;
  assign count     = slab_q >> chunk_sh;
  assign count_eff = (count == '0) ? SLAB_W'(1) : count;
  assign total32   = 32'(count_eff) << chunk_sh;

  // granule indexes
  assign addr_wide  = 32'(addr_q);
  assign free_gran  = addr_wide[MIN_SHIFT +: GRAN_W];
  assign carve_gran = carve_addr[MIN_SHIFT +: GRAN_W];
  assign grant32    = 32'(head_gran) << MIN_SHIFT;

  // status to controller
  always_comb begin
    sts            = '0;
    sts.op_free    = (op_q == ssca_pkg::OP_FREE);
    sts.zero       = (size_q == '0);
    sts.too_big    = (32'(size_q) > 32'(slab_q >> 1)) || !found;
    sts.head_empty = (head == '0);
    sts.oom        = total32 > (32'(POOL_BYTES) - 32'(bump));
    sts.bad_addr   = (addr_q[MIN_SHIFT-1:0] != '0) || (addr_wide >= 32'(POOL_BYTES));
    sts.carve_last = (carve_left == '0);
    sts.clear_last = (clr_idx == GRAN_W'(GRANULES - 1));
    sts.rec_bad    = (rec == '0) || (32'(rec) > 32'(NUM_CLASSES));
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      slab_q <= ssca_pkg::SLAB_RESET;
    end else if (cfg_we) begin
      slab_q <= cfg_wdata;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= op;
      size_q <= size;
      addr_q <= addr;
    end
  end

  // class list heads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        heads[k] <= '0;
      end
    end else if (cmd.carve_step) begin
      heads[cls] <= LINK_W'(carve_gran) + LINK_W'(1);
    end else if (cmd.pop_write) begin
      heads[cls] <= link_rdata;
    end else if (cmd.free_write) begin
      heads[free_cls] <= LINK_W'(free_gran) + LINK_W'(1);
    end
  end

  // bump pointer and carve walker
  always_ff @(posedge clk) begin
    if (rst) begin
      bump <= '0;
    end else if (cmd.carve_step && carve_left == '0) begin
      bump <= carve_addr + BUMP_W'(chunk32);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.carve_init) begin
      carve_addr <= bump;
      carve_left <= count_eff - SLAB_W'(1);
    end else if (cmd.carve_step) begin
      carve_addr <= carve_addr + BUMP_W'(chunk32);
      carve_left <= carve_left - SLAB_W'(1);
    end
  end

  // clearing pass index for the granule record
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_step) begin
      clr_idx <= clr_idx + GRAN_W'(1);
    end
  end

  // link store: written by carve and free, read at the head
  assign link_we    = cmd.carve_step || cmd.free_write;
  assign link_waddr = cmd.carve_step ? carve_gran : free_gran;

  ssca_ram #(.WIDTH(LINK_W), .DEPTH(GRANULES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (head),
    .raddr (head_gran),
    .rdata (link_rdata)
  );

  // granule record: cleared, set on grant, cleared on free
  assign rec_we    = cmd.clear_step || cmd.pop_write || cmd.free_write;
  assign rec_waddr = cmd.clear_step ? clr_idx : (cmd.pop_write ? head_gran : free_gran);
  assign rec_wdata = cmd.pop_write ? (REC_W'(cls) + REC_W'(1)) : '0;

  ssca_ram #(.WIDTH(REC_W), .DEPTH(GRANULES)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (free_gran),
    .rdata (rec)
  );

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      status_q     <= cmd.resp_status;
      alloc_addr_q <= cmd.resp_grant ? grant32[ssca_pkg::ADDR_W-1:0] : '0;
    end
  end

  assign done       = done_q;
  assign status     = status_q;
  assign alloc_addr = alloc_addr_q;

  // carving only happens on behalf of an allocate
  a_carve_alloc: assert property (@(posedge clk) disable iff (rst)
    cmd.carve_step |-> (op_q == ssca_pkg::OP_ALLOC))
    else $error("slab carve during a free");

  // the bump pointer never passes the end of the pool
  a_bump_bound: assert property (@(posedge clk) disable iff (rst)
    32'(bump) <= 32'(POOL_BYTES))
    else $error("bump pointer beyond pool");

  // a failed item never reports an address
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (done_q && status_q != ssca_pkg::ST_OK) |-> (alloc_addr_q == '0))
    else $error("address reported with failing status");

endmodule

// ===== sv/slab_size_class_allocator.sv =====
// top level of the power-of-two size class slab allocator
// order: a list-hit allocate passes check, pop read and pop write; a free passes check,
//   free read and free check; zero size, too large, out of memory and bad-address free
//   answer from check. An empty list first carves max(1, slab_bytes/chunk) chunks,
//   one link write each. Results cannot be held off; the next item is taken in the strobe
//   cycle, not earlier.
// reset: synchronous; a clearing pass writes all POOL_BYTES/MIN_CHUNK granule records (8192 by default)
//   while busy stays high; configuration writes are taken throughout
`timescale 1ns / 1ps

module slab_size_class_allocator #(
  parameter int POOL_BYTES  = ssca_pkg::POOL_BYTES_DEF,
  parameter int MIN_CHUNK   = ssca_pkg::MIN_CHUNK_DEF,
  parameter int NUM_CLASSES = ssca_pkg::NUM_CLASSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ssca_pkg::SLAB_W-1:0]   cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [ssca_pkg::SIZE_W-1:0]   size,
  input  logic [ssca_pkg::ADDR_W-1:0]   addr,
  output logic                          done,
  output logic [ssca_pkg::ADDR_W-1:0]   alloc_addr,
  output logic [ssca_pkg::STATUS_W-1:0] status
);

  ssca_pkg::cmd_t cmd;
  ssca_pkg::sts_t sts;

  // sequencer
  ssca_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // free lists, records and result register
  ssca_dp #(
    .POOL_BYTES  (POOL_BYTES),
    .MIN_CHUNK   (MIN_CHUNK),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .op         (op),
    .size       (size),
    .addr       (addr),
    .cmd        (cmd),
    .sts        (sts),
    .done       (done),
    .alloc_addr (alloc_addr),
    .status     (status)
  );

endmodule

// ===== tb/tb_slab_size_class_allocator.sv =====
// self-checking testbench for the slab size class allocator: queued stimulus, predictor, monitor
`timescale 1ns / 1ps

module tb_slab_size_class_allocator;
  import ssca_pkg::*;

  localparam int POOL   = POOL_BYTES_DEF;
  localparam int MINC   = MIN_CHUNK_DEF;
  localparam int NCLS   = NUM_CLASSES_DEF;
  localparam int GRAN   = POOL / MINC;
  localparam int SETTLE = 4;

  typedef enum logic [1:0] {REQ_ITEM, REQ_CFG, REQ_DRAIN} req_kind_t;
  typedef enum logic [1:0] {ADDR_FIXED, ADDR_LIVE, ADDR_FREED} addr_src_t;

  typedef struct {
    req_kind_t         kind;
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    addr_src_t         src;
    logic [SLAB_W-1:0] slab;
    bit                steady;
  } alloc_req_t;

  typedef struct {
    logic [ADDR_W-1:0] grant;
    status_t           code;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [SLAB_W-1:0]   cfg_wdata = '0;
  logic                start = 1'b0;
  logic                op = OP_ALLOC;
  logic [SIZE_W-1:0]   size = '0;
  logic [ADDR_W-1:0]   addr = '0;
  logic                busy;
  logic                done;
  logic [ADDR_W-1:0]   alloc_addr;
  logic [STATUS_W-1:0] status;

  slab_size_class_allocator dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .size       (size),
    .addr       (addr),
    .done       (done),
    .alloc_addr (alloc_addr),
    .status     (status)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // allocator state mirrored by the predictor
  logic [13:0]       next_link [GRAN];
  logic [13:0]       list_head [NCLS];
  logic [4:0]        owner_class [GRAN];
  logic [16:0]       bump_ptr;
  logic [SLAB_W-1:0] slab_cfg;
  logic [ADDR_W-1:0] live_q [$];
  logic [ADDR_W-1:0] last_freed;
  bit                have_freed;

  alloc_req_t request_q [$];
  outcome_t   outcome_q [$];
  int         fail_count = 0;

  // push a free chunk onto the head of its class list
  function automatic void push_free_chunk(int cls, int g);
    next_link[g]   = list_head[cls];
    list_head[cls] = 14'(g + 1);
  endfunction

  // compute the outcome of one accepted item and update the mirrored state
  function automatic outcome_t predict_alloc_outcome(logic op_i, logic [SIZE_W-1:0] size_i,
                                                     logic [ADDR_W-1:0] addr_i);
    outcome_t res;
    int need, cls, chunk, count, total, g, i, idx, rec;
    res.grant = '0;
    res.code  = ST_OK;
    if (op_i == OP_ALLOC) begin
      if (size_i == 0) begin
        res.code = ST_ZERO;
      end else if (int'(size_i) > int'(slab_cfg) / 2) begin
        res.code = ST_LARGE;
      end else begin
        need = (int'(size_i) < MINC) ? MINC : int'(size_i);
        cls = 0;
        while (cls < NCLS && (MINC << cls) < need) cls++;
        if (cls >= NCLS) begin
          res.code = ST_LARGE;
        end else begin
          chunk = MINC << cls;
          // empty list: carve a whole slab at the bump pointer
          if (list_head[cls] == 0) begin
            count = int'(slab_cfg) / chunk;
            if (count == 0) count = 1;
            total = count * chunk;
            if (int'(bump_ptr) > POOL || total > POOL - int'(bump_ptr)) begin
              res.code = ST_OOM;
            end else begin
              for (i = 0; i < count; i++)
                push_free_chunk(cls, (int'(bump_ptr) + i * chunk) / MINC);
              bump_ptr = 17'(int'(bump_ptr) + total);
            end
          end
          if (res.code == ST_OK) begin
            g = (int'(list_head[cls]) - 1) % GRAN;
            list_head[cls] = next_link[g];
            owner_class[g] = 5'(cls + 1);
            res.grant = ADDR_W'(g * MINC);
            live_q.insert(live_q.size(), res.grant);
          end
        end
      end
    end else begin
      if (int'(addr_i) % MINC != 0 || int'(addr_i) >= POOL) begin
        res.code = ST_BADFREE;
      end else begin
        g = int'(addr_i) / MINC;
        rec = int'(owner_class[g]);
        if (rec == 0 || rec > NCLS) begin
          res.code = ST_BADFREE;
        end else begin
          owner_class[g] = '0;
          push_free_chunk(rec - 1, g);
          idx = -1;
          foreach (live_q[j]) if (idx < 0 && live_q[j] == addr_i) idx = j;
          if (idx >= 0) live_q.delete(idx);
          last_freed = addr_i;
          have_freed = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // driver: predicts accepted items, applies config writes, presents the next item
  logic              hold_item;
  logic              start_n;
  logic              cfg_we_n;
  logic [ADDR_W-1:0] pick_addr;
  int                settle_cnt = 0;
  alloc_req_t        head_req;

  always @(posedge clk) begin
    if (!rst) begin
      hold_item = start && busy;
      start_n   = hold_item;
      cfg_we_n  = 1'b0;
      if (start && !busy)
        outcome_q.insert(outcome_q.size(), predict_alloc_outcome(op, size, addr));
      if (cfg_we) slab_cfg = cfg_wdata;
      if (!hold_item && request_q.size() > 0) begin
        head_req = request_q[0];
        if (head_req.kind == REQ_ITEM) begin
          settle_cnt = 0;
          if (head_req.steady || $urandom_range(0, 99) >= 18) begin
            pick_addr = head_req.addr;
            if (head_req.src == ADDR_LIVE && live_q.size() > 0)
              pick_addr = live_q[$urandom_range(0, live_q.size() - 1)];
            else if (head_req.src == ADDR_FREED && have_freed)
              pick_addr = last_freed;
            op   <= head_req.op;
            size <= head_req.size;
            addr <= pick_addr;
            start_n = 1'b1;
            void'(request_q.pop_front());
          end
        end else if (outcome_q.size() == 0 && !busy) begin
          // block idle: count settle_cnt up to SETTLE before a config write or the end of a drain
          if (settle_cnt < SETTLE) begin
            settle_cnt++;
          end else begin
            settle_cnt = 0;
            if (head_req.kind == REQ_CFG) begin
              cfg_wdata <= head_req.slab;
              cfg_we_n = 1'b1;
            end
            void'(request_q.pop_front());
          end
        end
      end
      start  <= start_n;
      cfg_we <= cfg_we_n;
    end
  end

  // monitor: compare every strobed result with the oldest prediction
  outcome_t seen;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual addr %0d status %0d",
                 $time, alloc_addr, status);
        fail_count++;
      end else begin
        seen = outcome_q.pop_front();
        if (alloc_addr !== seen.grant) begin
          $display("%0t: alloc_addr mismatch, expected %0d, actual %0d",
                   $time, seen.grant, alloc_addr);
          fail_count++;
        end
        if (status !== seen.code) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, seen.code, status);
          fail_count++;
        end
      end
    end
  end

  // stimulus builders
  bit steady_gen = 1'b0;

  task automatic add_item(logic op_i, int size_i, int addr_i, addr_src_t src_i);
    alloc_req_t r;
    r.kind   = REQ_ITEM;
    r.op     = op_i;
    r.size   = SIZE_W'(size_i);
    r.addr   = ADDR_W'(addr_i);
    r.src    = src_i;
    r.slab   = '0;
    r.steady = steady_gen;
    request_q.insert(request_q.size(), r);
  endtask

  task automatic add_ctrl(req_kind_t kind_i, int slab_i);
    alloc_req_t r;
    r.kind   = kind_i;
    r.op     = OP_ALLOC;
    r.size   = '0;
    r.addr   = '0;
    r.src    = ADDR_FIXED;
    r.slab   = SLAB_W'(slab_i);
    r.steady = 1'b0;
    request_q.insert(request_q.size(), r);
  endtask

  // stimulus and end of run
  int phase_slab [12] = '{16, 4096, 24, 8191, 100, 512, 17, 2048, 1000, 64, 300, 4096};
  int p, n, roll, alloc_cut, free_cut, limit, cls, lo, hi;
  bit heavy;

  initial begin
    // predictor reset state
    for (int g = 0; g < GRAN; g++) begin
      next_link[g]   = '0;
      owner_class[g] = '0;
    end
    for (int c = 0; c < NCLS; c++) list_head[c] = '0;
    bump_ptr   = '0;
    slab_cfg   = SLAB_RESET;
    have_freed = 1'b0;
    last_freed = '0;

    // tiny slab before any class 0 carve: one-chunk slabs, address 0 handed out
    add_ctrl(REQ_CFG, 6);
    add_item(OP_ALLOC, 1, 0, ADDR_FIXED);
    add_item(OP_ALLOC, 2, 0, ADDR_FIXED);
    add_item(OP_ALLOC, 3, 0, ADDR_FIXED);
    add_item(OP_ALLOC, 4, 0, ADDR_FIXED);
    add_item(OP_ALLOC, 0, 0, ADDR_FIXED);
    add_item(OP_FREE, 0, 0, ADDR_FIXED);
    add_item(OP_FREE, 0, 0, ADDR_FIXED);
    add_item(OP_ALLOC, 1, 0, ADDR_FIXED);
    // default slab: every class, size limits, bad frees
    add_ctrl(REQ_DRAIN, 0);
    add_ctrl(REQ_CFG, 4096);
    add_item(OP_ALLOC, 8, 0, ADDR_FIXED);
    add_item(OP_ALLOC, 9, 0, ADDR_FIXED);
    add_item(OP_ALLOC, 2048, 0, ADDR_FIXED);
    add_item(OP_ALLOC, 2049, 0, ADDR_FIXED);
    add_item(OP_ALLOC, 65535, 0, ADDR_FIXED);
    add_item(OP_FREE, 0, 0, ADDR_LIVE);
    add_item(OP_FREE, 0, 0, ADDR_FREED);
    add_item(OP_FREE, 0, 3, ADDR_FIXED);
    add_item(OP_FREE, 0, 65528, ADDR_FIXED);
    for (int k = 1; k <= 7; k++) add_item(OP_ALLOC, 8 << k, 0, ADDR_FIXED);
    add_item(OP_FREE, 0, 0, ADDR_LIVE);
    // oversized slab: class past the last one
    add_ctrl(REQ_DRAIN, 0);
    add_ctrl(REQ_CFG, 8191);
    add_item(OP_ALLOC, 4000, 0, ADDR_FIXED);
    add_item(OP_ALLOC, 4095, 0, ADDR_FIXED);

    // random phases, one slab setting each
    for (p = 0; p < 12; p++) begin
      add_ctrl(REQ_DRAIN, 0);
      add_ctrl(REQ_CFG, phase_slab[p]);
      steady_gen = (p == 5);
      heavy      = (p == 3 || p == 11);
      alloc_cut  = heavy ? 75 : 45;
      free_cut   = alloc_cut + (heavy ? 10 : 35);
      for (n = 0; n < 150; n++) begin
        if ($urandom_range(0, 99) < 1) add_ctrl(REQ_DRAIN, 0);
        roll = $urandom_range(0, 99);
        if (roll < alloc_cut) begin
          // well-formed size, spread over the classes
          limit = phase_slab[p] / 2;
          if (limit < 1) limit = 1;
          cls = $urandom_range(0, 9);
          hi  = 8 << cls;
          if (hi > limit) hi = limit;
          lo = (cls == 0) ? 1 : (4 << cls) + 1;
          if (lo > hi) lo = 1;
          add_item(OP_ALLOC, $urandom_range(lo, hi), 0, ADDR_FIXED);
        end else if (roll < free_cut) begin
          add_item(OP_FREE, 0, $urandom & 16'hFFF8, ADDR_LIVE);
        end else if (roll < free_cut + 5) begin
          add_item(OP_FREE, 0, $urandom & 16'hFFF8, ADDR_FREED);
        end else if (roll < free_cut + 7) begin
          add_item(OP_FREE, $urandom & 16'hFFFF, $urandom & 16'hFFF8, ADDR_FIXED);
        end else if (roll < free_cut + 9) begin
          add_item(OP_FREE, $urandom & 16'hFFFF, $urandom & 16'hFFFF, ADDR_FIXED);
        end else if (roll < free_cut + 12) begin
          add_item(OP_ALLOC, $urandom & 16'hFFFF, $urandom & 16'hFFFF, ADDR_FIXED);
        end else begin
          add_item(OP_ALLOC, $urandom_range(0, 15), 0, ADDR_FIXED);
        end
      end
    end
    steady_gen = 1'b0;

    // reset, then wait for everything to drain, sampled once the edge has settled
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (request_q.size() > 0 || start || busy || outcome_q.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ssca_pkg.sv
sv/ssca_ram.sv
sv/ssca_ctrl.sv
sv/ssca_dp.sv
sv/slab_size_class_allocator.sv
tb/tb_slab_size_class_allocator.sv
